// ===== sv/tmhq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tmhq_pkg;

  // sizes of the table defaults
  localparam int unsigned MAX_VERTICES_DEF  = 1024;
  localparam int unsigned MAX_TRIANGLES_DEF = 1024;

  // field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CRD_W    = 32;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TRI_W    = 3 * IDX_W;

  // datapath widths
  localparam int unsigned DIF_W   = CRD_W + 1;
  localparam int unsigned PRD_W   = 2 * DIF_W;
  localparam int unsigned CRS_W   = PRD_W + 1;
  localparam int unsigned MAG_W   = PRD_W;
  localparam int unsigned CHUNK_W = MAG_W / 2;
  localparam int unsigned PP_W    = CHUNK_W + 1 + CRD_W;
  localparam int unsigned ACC_W   = MAG_W + CRD_W + 2;
  localparam int unsigned NUM_W   = ACC_W - 1;

  // input queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD_VERTEX   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_TRIANGLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY        = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_IDX  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DEGEN   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

  localparam logic [CRD_W-1:0] HEIGHT_MIN = 32'h8000_0000;
  localparam logic [CRD_W-1:0] HEIGHT_MAX = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    OP_VERTEX   = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_QUERY    = 2'd2,
    OP_INVALID  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
    logic [IDX_W-1:0]        a;
    logic [IDX_W-1:0]        b;
    logic [IDX_W-1:0]        c;
  } item_t;

endpackage
`default_nettype wire

// ===== sv/tmhq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmhq_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [tmhq_pkg::CMD_W-1:0]           cmd_i,
  input  wire logic signed [tmhq_pkg::CRD_W-1:0]    coord_x_i,
  input  wire logic signed [tmhq_pkg::CRD_W-1:0]    coord_y_i,
  input  wire logic signed [tmhq_pkg::CRD_W-1:0]    coord_z_i,
  input  wire logic [tmhq_pkg::IDX_W-1:0]           corner_a_i,
  input  wire logic [tmhq_pkg::IDX_W-1:0]           corner_b_i,
  input  wire logic [tmhq_pkg::IDX_W-1:0]           corner_c_i,
  input  wire logic                                 q_full_i,
  output logic                                      q_push_o,
  output tmhq_pkg::item_t                           q_item_o
);

  logic            vld_q;
  tmhq_pkg::item_t item_q;
  tmhq_pkg::item_t item_d;
  logic            accept;

  // classify the command
  always_comb begin
    item_d.x = coord_x_i;
    item_d.y = coord_y_i;
    item_d.z = coord_z_i;
    item_d.a = corner_a_i;
    item_d.b = corner_b_i;
    item_d.c = corner_c_i;
    unique case (cmd_i)
      tmhq_pkg::CMD_ADD_VERTEX:   item_d.op = tmhq_pkg::OP_VERTEX;
      tmhq_pkg::CMD_ADD_TRIANGLE: item_d.op = tmhq_pkg::OP_TRIANGLE;
      tmhq_pkg::CMD_QUERY:        item_d.op = tmhq_pkg::OP_QUERY;
      default:                    item_d.op = tmhq_pkg::OP_INVALID;
    endcase
  end

  assign q_push_o   = vld_q && !q_full_i;
  assign in_stall_o = vld_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_item_o   = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (q_push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tmhq_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmhq_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tmhq_pkg::item_t item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output tmhq_pkg::item_t      head_o
);

  localparam int unsigned PW = tmhq_pkg::QPW;
  localparam int unsigned DEPTH = tmhq_pkg::QDEPTH;

  tmhq_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]   wptr_q;
  logic [PW-1:0]   rptr_q;
  logic [PW:0]     cnt_q;

  function automatic logic [PW-1:0] ptr_next(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign full_o  = cnt_q == (PW + 1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sv/tmhq_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmhq_div #(
  parameter int unsigned NUM_W = tmhq_pkg::NUM_W,
  parameter int unsigned DEN_W = tmhq_pkg::MAG_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned CNW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNW-1:0]   cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      rem_q  <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      quot_q <= {quot_q[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== sv/tmhq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmhq_back #(
  parameter int unsigned MAX_VERTICES  = tmhq_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_TRIANGLES = tmhq_pkg::MAX_TRIANGLES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_empty_i,
  input  wire tmhq_pkg::item_t                   q_head_i,
  output logic                                   q_pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [tmhq_pkg::STATUS_W-1:0]          status_o,
  output logic [tmhq_pkg::IDX_W-1:0]             slot_o,
  output logic signed [tmhq_pkg::CRD_W-1:0]      height_o
);

  localparam int unsigned VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned TCW = $clog2(MAX_TRIANGLES + 1);
  localparam int unsigned IW  = tmhq_pkg::IDX_W;
  localparam int unsigned CMW = (VCW > IW) ? VCW : IW;
  localparam int unsigned CW  = tmhq_pkg::CRD_W;
  localparam int unsigned DW  = tmhq_pkg::DIF_W;
  localparam int unsigned PW  = tmhq_pkg::PRD_W;
  localparam int unsigned XW  = tmhq_pkg::CRS_W;
  localparam int unsigned MW  = tmhq_pkg::MAG_W;
  localparam int unsigned KW  = tmhq_pkg::CHUNK_W;
  localparam int unsigned AW  = tmhq_pkg::ACC_W;
  localparam int unsigned NW  = tmhq_pkg::NUM_W;
  localparam int unsigned SW  = tmhq_pkg::STATUS_W;
  localparam int unsigned NUM_STEPS = 6;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_EXEC     = 15'b000000000000010,
    ST_FETCH_T  = 15'b000000000000100,
    ST_FETCH_A  = 15'b000000000001000,
    ST_FETCH_B  = 15'b000000000010000,
    ST_FETCH_C  = 15'b000000000100000,
    ST_DIFF     = 15'b000000001000000,
    ST_MUL      = 15'b000000010000000,
    ST_SUM      = 15'b000000100000000,
    ST_CHECK    = 15'b000001000000000,
    ST_NUM_MUL  = 15'b000010000000000,
    ST_NUM_ADD  = 15'b000100000000000,
    ST_DIV_GO   = 15'b001000000000000,
    ST_DIV_WAIT = 15'b010000000000000,
    ST_DONE     = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [VCW-1:0] vcnt_q;
  logic [TCW-1:0] tcnt_q;
  logic [TCW-1:0] t_q;
  tmhq_pkg::item_t cur_q;

  // tables
  logic signed [CW-1:0]        vx_mem [MAX_VERTICES];
  logic signed [CW-1:0]        vy_mem [MAX_VERTICES];
  logic signed [CW-1:0]        vz_mem [MAX_VERTICES];
  logic [tmhq_pkg::TRI_W-1:0]  tri_mem [MAX_TRIANGLES];
  logic signed [CW-1:0]        vx_rd_q, vy_rd_q, vz_rd_q;
  logic [tmhq_pkg::TRI_W-1:0]  tri_rd_q;
  logic [VAW-1:0]              v_raddr;
  logic                        v_we, t_we;

  // corner registers and cross product pipeline
  logic signed [CW-1:0] x1_q, y1_q, z1_q, x2_q, y2_q, z2_q, z3_q;
  logic signed [DW-1:0] e1x_q, e1y_q, e2x_q, e2y_q;
  logic signed [DW-1:0] u1x_q, u1y_q, u2x_q, u2y_q, u3x_q, u3y_q;
  logic signed [PW-1:0] pd0_q, pd1_q, p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q;
  logic signed [XW-1:0] d_q, w1_q, w2_q, w3_q;
  logic signed [XW-1:0] wn1, wn2, wn3, dn;
  logic [MW-1:0]        wn1_q, wn2_q, wn3_q, dn_q;

  // numerator accumulation
  logic [2:0]                  k_q;
  logic                        hi_q;
  logic [KW-1:0]               chunk;
  logic [MW-1:0]               wsel;
  logic signed [CW-1:0]        zsel;
  logic signed [tmhq_pkg::PP_W-1:0] pp_d, pp_q;
  logic signed [AW-1:0]        acc_q, acc_add;

  // result and output registers
  logic [SW-1:0]        res_status_q, out_status_q;
  logic [IW-1:0]        res_slot_q, out_slot_q;
  logic signed [CW-1:0] res_height_q, out_height_q;
  logic                 out_valid_q;

  logic              is_query, vtx_full, tri_full, bad_idx, d_zero, in_tri, last_tri;
  logic              out_free;
  logic [IW-1:0]     crn_a, crn_b, crn_c;
  logic              div_start, div_done;
  logic [NW-1:0]     div_num, div_quot;
  logic              q_hi_zero, sat;
  logic signed [CW-1:0] hgt;

  function automatic logic signed [DW-1:0] sub33(logic signed [CW-1:0] a,
                                                 logic signed [CW-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  assign is_query = cur_q.op == tmhq_pkg::OP_QUERY;
  assign vtx_full = vcnt_q == VCW'(MAX_VERTICES);
  assign tri_full = tcnt_q == TCW'(MAX_TRIANGLES);
  assign bad_idx  = (CMW'(cur_q.a) >= CMW'(vcnt_q)) || (CMW'(cur_q.b) >= CMW'(vcnt_q)) ||
                    (CMW'(cur_q.c) >= CMW'(vcnt_q));
  assign last_tri = TCW'(t_q + 1'b1) == tcnt_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  // corners come from the stored triangle on a query, else from the command
  assign crn_a = is_query ? tri_rd_q[IW-1:0]      : cur_q.a;
  assign crn_b = is_query ? tri_rd_q[2*IW-1:IW]   : cur_q.b;
  assign crn_c = is_query ? tri_rd_q[3*IW-1:2*IW] : cur_q.c;

  always_comb begin
    priority if (state_q == ST_FETCH_A) begin
      v_raddr = VAW'(crn_a);
    end else if (state_q == ST_FETCH_B) begin
      v_raddr = VAW'(crn_b);
    end else begin
      v_raddr = VAW'(crn_c);
    end
  end

  assign v_we = (state_q == ST_EXEC) && (cur_q.op == tmhq_pkg::OP_VERTEX) && !vtx_full;
  assign t_we = (state_q == ST_CHECK) && !is_query && !d_zero;

  // sign normalization by the area term
  assign d_zero = d_q == '0;
  assign wn1    = d_q[XW-1] ? -w1_q : w1_q;
  assign wn2    = d_q[XW-1] ? -w2_q : w2_q;
  assign wn3    = d_q[XW-1] ? -w3_q : w3_q;
  assign dn     = d_q[XW-1] ? -d_q  : d_q;
  assign in_tri = !wn1[XW-1] && !wn2[XW-1] && !wn3[XW-1];

  // one partial product of weight times height per step
  always_comb begin
    unique case (k_q[2:1])
      2'd0:    begin wsel = wn1_q; zsel = z1_q; end
      2'd1:    begin wsel = wn2_q; zsel = z2_q; end
      default: begin wsel = wn3_q; zsel = z3_q; end
    endcase
    chunk = k_q[0] ? wsel[MW-1:KW] : wsel[KW-1:0];
    pp_d  = $signed({1'b0, chunk}) * zsel;
  end

  assign acc_add = hi_q ? (AW'(pp_q) <<< KW) : AW'(pp_q);
  assign div_num = acc_q[AW-1] ? NW'(-acc_q) : NW'(acc_q);

  // truncated quotient, saturated to 32 bits
  assign q_hi_zero = div_quot[NW-1:CW] == '0;
  always_comb begin
    if (acc_q[AW-1]) begin
      sat = !q_hi_zero || (div_quot[CW-1] && (div_quot[CW-2:0] != '0));
      hgt = sat ? tmhq_pkg::HEIGHT_MIN : -$signed(div_quot[CW-1:0]);
    end else begin
      sat = !q_hi_zero || div_quot[CW-1];
      hgt = sat ? tmhq_pkg::HEIGHT_MAX : $signed(div_quot[CW-1:0]);
    end
  end

  assign div_start = state_q == ST_DIV_GO;

  tmhq_div #(
    .NUM_W(NW),
    .DEN_W(MW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (dn_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (cur_q.op)
          tmhq_pkg::OP_VERTEX:   state_d = ST_DONE;
          tmhq_pkg::OP_TRIANGLE: state_d = (tri_full || bad_idx) ? ST_DONE : ST_FETCH_A;
          tmhq_pkg::OP_QUERY:    state_d = (tcnt_q == '0) ? ST_DONE : ST_FETCH_T;
          tmhq_pkg::OP_INVALID:  state_d = ST_DONE;
        endcase
      end
      ST_FETCH_T: state_d = ST_FETCH_A;
      ST_FETCH_A: state_d = ST_FETCH_B;
      ST_FETCH_B: state_d = ST_FETCH_C;
      ST_FETCH_C: state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_MUL;
      ST_MUL:     state_d = ST_SUM;
      ST_SUM:     state_d = ST_CHECK;
      ST_CHECK: begin
        priority if (!is_query) begin
          state_d = ST_DONE;
        end else if (!d_zero && in_tri) begin
          state_d = ST_NUM_MUL;
        end else if (last_tri) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_FETCH_T;
        end
      end
      ST_NUM_MUL: state_d = ST_NUM_ADD;
      ST_NUM_ADD: state_d = (k_q == 3'(NUM_STEPS - 1)) ? ST_DIV_GO : ST_NUM_MUL;
      ST_DIV_GO:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcnt_q      <= '0;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (v_we) vcnt_q <= vcnt_q + 1'b1;
      if (t_we) tcnt_q <= tcnt_q + 1'b1;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // memories, registered read
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vx_mem[vcnt_q[VAW-1:0]] <= cur_q.x;
      vy_mem[vcnt_q[VAW-1:0]] <= cur_q.y;
      vz_mem[vcnt_q[VAW-1:0]] <= cur_q.z;
    end
    vx_rd_q <= vx_mem[v_raddr];
    vy_rd_q <= vy_mem[v_raddr];
    vz_rd_q <= vz_mem[v_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tri_mem[tcnt_q[TAW-1:0]] <= {cur_q.c, cur_q.b, cur_q.a};
    end
    tri_rd_q <= tri_mem[t_q[TAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) cur_q <= q_head_i;
      end
      ST_EXEC: begin
        res_slot_q   <= '0;
        res_height_q <= '0;
        t_q          <= '0;
        unique case (cur_q.op)
          tmhq_pkg::OP_VERTEX: begin
            if (vtx_full) begin
              res_status_q <= tmhq_pkg::STAT_FULL;
            end else begin
              res_status_q <= tmhq_pkg::STAT_OK;
              res_slot_q   <= IW'(vcnt_q);
            end
          end
          tmhq_pkg::OP_TRIANGLE: begin
            res_status_q <= tri_full ? tmhq_pkg::STAT_FULL : tmhq_pkg::STAT_BAD_IDX;
          end
          tmhq_pkg::OP_QUERY:   res_status_q <= tmhq_pkg::STAT_NOTFOUND;
          tmhq_pkg::OP_INVALID: res_status_q <= tmhq_pkg::STAT_BAD_IDX;
        endcase
      end
      ST_FETCH_B: begin
        x1_q <= vx_rd_q;
        y1_q <= vy_rd_q;
        z1_q <= vz_rd_q;
      end
      ST_FETCH_C: begin
        x2_q <= vx_rd_q;
        y2_q <= vy_rd_q;
        z2_q <= vz_rd_q;
      end
      ST_DIFF: begin
        z3_q  <= vz_rd_q;
        e1x_q <= sub33(x2_q, x1_q);
        e1y_q <= sub33(y2_q, y1_q);
        e2x_q <= sub33(vx_rd_q, x1_q);
        e2y_q <= sub33(vy_rd_q, y1_q);
        u1x_q <= sub33(x1_q, cur_q.x);
        u1y_q <= sub33(y1_q, cur_q.y);
        u2x_q <= sub33(x2_q, cur_q.x);
        u2y_q <= sub33(y2_q, cur_q.y);
        u3x_q <= sub33(vx_rd_q, cur_q.x);
        u3y_q <= sub33(vy_rd_q, cur_q.y);
      end
      ST_MUL: begin
        pd0_q <= e1x_q * e2y_q;
        pd1_q <= e1y_q * e2x_q;
        p1a_q <= u2x_q * u3y_q;
        p1b_q <= u2y_q * u3x_q;
        p2a_q <= u3x_q * u1y_q;
        p2b_q <= u3y_q * u1x_q;
        p3a_q <= u1x_q * u2y_q;
        p3b_q <= u1y_q * u2x_q;
      end
      ST_SUM: begin
        d_q  <= XW'(pd0_q) - XW'(pd1_q);
        w1_q <= XW'(p1a_q) - XW'(p1b_q);
        w2_q <= XW'(p2a_q) - XW'(p2b_q);
        w3_q <= XW'(p3a_q) - XW'(p3b_q);
      end
      ST_CHECK: begin
        if (!is_query) begin
          if (d_zero) begin
            res_status_q <= tmhq_pkg::STAT_DEGEN;
          end else begin
            res_status_q <= tmhq_pkg::STAT_OK;
            res_slot_q   <= IW'(tcnt_q);
          end
        end else if (!d_zero && in_tri) begin
          wn1_q <= MW'(wn1);
          wn2_q <= MW'(wn2);
          wn3_q <= MW'(wn3);
          dn_q  <= MW'(dn);
          acc_q <= '0;
          k_q   <= '0;
        end else if (!last_tri) begin
          t_q <= TCW'(t_q + 1'b1);
        end
      end
      ST_NUM_MUL: begin
        pp_q <= pp_d;
        hi_q <= k_q[0];
      end
      ST_NUM_ADD: begin
        acc_q <= acc_q + acc_add;
        k_q   <= k_q + 1'b1;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_status_q <= tmhq_pkg::STAT_OK;
          res_slot_q   <= IW'(t_q);
          res_height_q <= hgt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_height_q <= res_height_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign height_o    = out_height_q;

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE)) else $error("result without done");

  a_tcnt_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tcnt_q != $past(tcnt_q)) |-> $past(state_q == ST_CHECK))
    else $error("triangle count moved outside check");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV_WAIT) else $error("divider finished unexpectedly");

endmodule
`default_nettype wire

// ===== sv/triangle_mesh_height_query_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// triangle mesh height query unit
// input channel: in_valid_i / in_stall_o with cmd_i, coord_x/y/z_i, corner_a/b/c_i;
//   a transaction completes on a rising edge with valid high and stall low
// output channel: out_valid_o / out_stall_i with status_o, slot_o, height_o;
//   every input transaction yields exactly one output transaction, in order
// a front register decodes the command into a two-entry queue; the back end
//   executes one item at a time against the vertex and triangle memories
// a query scans the stored triangles in order; a hit adds six multiply/add
//   steps, a divider start state and the restoring divider
// the back end finishes one item before it takes the next
// the step for each scanned triangle is set by the single read port of the
//   vertex memory (three corner reads) and the difference / product / sum stages
// up to three further transactions are taken while the back end is busy
// reset clears the vertex and triangle counts and all handshake state;
//   memory contents are left as they are and are never used before written
// a stalled output holds its transaction; the back end waits at its result
//   and the queue fills, after which in_stall_o goes high
module triangle_mesh_height_query_unit #(
  parameter int unsigned MAX_VERTICES  = tmhq_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_TRIANGLES = tmhq_pkg::MAX_TRIANGLES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [tmhq_pkg::CMD_W-1:0]         cmd_i,
  input  wire logic signed [tmhq_pkg::CRD_W-1:0]  coord_x_i,
  input  wire logic signed [tmhq_pkg::CRD_W-1:0]  coord_y_i,
  input  wire logic signed [tmhq_pkg::CRD_W-1:0]  coord_z_i,
  input  wire logic [tmhq_pkg::IDX_W-1:0]         corner_a_i,
  input  wire logic [tmhq_pkg::IDX_W-1:0]         corner_b_i,
  input  wire logic [tmhq_pkg::IDX_W-1:0]         corner_c_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [tmhq_pkg::STATUS_W-1:0]           status_o,
  output logic [tmhq_pkg::IDX_W-1:0]              slot_o,
  output logic signed [tmhq_pkg::CRD_W-1:0]       height_o
);

  // front to queue
  logic            q_push;
  logic            q_full;
  tmhq_pkg::item_t q_item;

  // queue to back end
  logic            q_pop;
  logic            q_empty;
  tmhq_pkg::item_t q_head;

  tmhq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .coord_z_i  (coord_z_i),
    .corner_a_i (corner_a_i),
    .corner_b_i (corner_b_i),
    .corner_c_i (corner_c_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_item)
  );

  tmhq_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  // execution: table updates, triangle scan, interpolation
  tmhq_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .slot_o     (slot_o),
    .height_o   (height_o)
  );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tmhq_pkg::*;

  // longest stretch with no transaction on either channel before giving up;
  // it must cover a query over the hundred or so stored triangles with a hit,
  // and up to three more can sit queued behind a stalled output
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned NUM_RANDOM  = 512;
  // keeps random queries short
  localparam int unsigned RAND_TRI_CAP = 90;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [IDX_W-1:0]        slot;
    logic signed [CRD_W-1:0] height;
  } result_t;

  // one row of the directed stimulus; typed_exp marks rows checked against
  // the expectation written in the row instead of the mesh predictor
  typedef struct {
    item_t   item;
    bit      typed_exp;
    result_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [CMD_W-1:0] cmd_i = '0;
  logic signed [CRD_W-1:0] coord_x_i = '0;
  logic signed [CRD_W-1:0] coord_y_i = '0;
  logic signed [CRD_W-1:0] coord_z_i = '0;
  logic [IDX_W-1:0] corner_a_i = '0;
  logic [IDX_W-1:0] corner_b_i = '0;
  logic [IDX_W-1:0] corner_c_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0] slot_o;
  logic signed [CRD_W-1:0] height_o;

  // predictor copy of the mesh
  logic signed [CRD_W-1:0] mesh_x [MAX_VERTICES_DEF];
  logic signed [CRD_W-1:0] mesh_y [MAX_VERTICES_DEF];
  logic signed [CRD_W-1:0] mesh_z [MAX_VERTICES_DEF];
  logic [IDX_W-1:0] tri_a [MAX_TRIANGLES_DEF];
  logic [IDX_W-1:0] tri_b [MAX_TRIANGLES_DEF];
  logic [IDX_W-1:0] tri_c [MAX_TRIANGLES_DEF];
  int unsigned vert_cnt = 0;
  int unsigned tri_cnt = 0;

  result_t pending_results[$];
  row_t directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  triangle_mesh_height_query_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .coord_z_i  (coord_z_i),
    .corner_a_i (corner_a_i),
    .corner_b_i (corner_b_i),
    .corner_c_i (corner_c_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .slot_o     (slot_o),
    .height_o   (height_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // twice the signed area of triangle (a, b, c), exact in 128 bits
  function automatic wide_t area2(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                  wide_t cx, wide_t cy);
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  function automatic wide_t corner_area(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                        logic [IDX_W-1:0] c);
    return area2(mesh_x[a], mesh_y[a], mesh_x[b], mesh_y[b], mesh_x[c], mesh_y[c]);
  endfunction

  // applies one transaction to the mesh copy and returns its result
  function automatic result_t mesh_predict(item_t it);
    result_t r;
    wide_t d, w1, w2, w3, num, q;
    wide_t lim_hi, lim_lo;
    logic [IDX_W-1:0] a, b, c;
    r = '0;
    lim_hi = 128'sd2147483647;
    lim_lo = -128'sd2147483648;
    case (it.op)
      OP_VERTEX: begin
        if (vert_cnt >= MAX_VERTICES_DEF) begin
          r.status = STAT_FULL;
        end else begin
          mesh_x[vert_cnt] = it.x;
          mesh_y[vert_cnt] = it.y;
          mesh_z[vert_cnt] = it.z;
          r.slot = IDX_W'(vert_cnt);
          vert_cnt++;
        end
      end
      OP_TRIANGLE: begin
        if (tri_cnt >= MAX_TRIANGLES_DEF) begin
          r.status = STAT_FULL;
        end else if (it.a >= vert_cnt || it.b >= vert_cnt || it.c >= vert_cnt) begin
          r.status = STAT_BAD_IDX;
        end else if (corner_area(it.a, it.b, it.c) == 0) begin
          r.status = STAT_DEGEN;
        end else begin
          tri_a[tri_cnt] = it.a;
          tri_b[tri_cnt] = it.b;
          tri_c[tri_cnt] = it.c;
          r.slot = IDX_W'(tri_cnt);
          tri_cnt++;
        end
      end
      OP_QUERY: begin
        r.status = STAT_NOTFOUND;
        for (int unsigned t = 0; t < tri_cnt; t++) begin
          a = tri_a[t];
          b = tri_b[t];
          c = tri_c[t];
          d = corner_area(a, b, c);
          if (d == 0) continue;
          w1 = area2(it.x, it.y, mesh_x[b], mesh_y[b], mesh_x[c], mesh_y[c]);
          w2 = area2(it.x, it.y, mesh_x[c], mesh_y[c], mesh_x[a], mesh_y[a]);
          w3 = area2(it.x, it.y, mesh_x[a], mesh_y[a], mesh_x[b], mesh_y[b]);
          // normalize the winding so that inside means all weights >= 0
          if (d < 0) begin
            d = -d;
            w1 = -w1;
            w2 = -w2;
            w3 = -w3;
          end
          if (w1 < 0 || w2 < 0 || w3 < 0) continue;
          num = w1 * wide_t'(mesh_z[a]) + w2 * wide_t'(mesh_z[b])
              + w3 * wide_t'(mesh_z[c]);
          q = num / d;  // truncates toward zero
          if (q > lim_hi) r.height = HEIGHT_MAX;
          else if (q < lim_lo) r.height = HEIGHT_MIN;
          else r.height = q[CRD_W-1:0];
          r.status = STAT_OK;
          r.slot = IDX_W'(t);
          break;
        end
      end
      default: r.status = STAT_BAD_IDX;
    endcase
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  function automatic void add_row(row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // drives one transaction; entered and left at a falling edge
  task automatic send_item(item_t it, bit typed_exp, result_t exp);
    result_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= it.op;
    coord_x_i  <= it.x;
    coord_y_i  <= it.y;
    coord_z_i  <= it.z;
    corner_a_i <= it.a;
    corner_b_i <= it.b;
    corner_c_i <= it.c;
    do @(posedge clk); while (in_stall_o);
    // transaction accepted at this edge
    r = mesh_predict(it);
    pending_results = {pending_results, (typed_exp ? exp : r)};
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [CRD_W-1:0] near_coord();
    if ($urandom_range(7) == 0) return $urandom;
    return $signed($urandom_range(32'h01ff_ffff)) - 32'sh0100_0000;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int unsigned pick, t, mode;
    longint sx, sy;
    it.op = OP_QUERY;
    it.x = $urandom;
    it.y = $urandom;
    it.z = $urandom;
    it.a = IDX_W'($urandom);
    it.b = IDX_W'($urandom);
    it.c = IDX_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.op = OP_VERTEX;
      it.x = near_coord();
      it.y = near_coord();
      if ($urandom_range(3) != 0) it.z = near_coord();
    end else if (pick < 45 && tri_cnt < RAND_TRI_CAP) begin
      it.op = OP_TRIANGLE;
      // mostly valid indices so that real triangles get stored
      if (vert_cnt > 0 && $urandom_range(9) != 0) begin
        it.a = IDX_W'($urandom_range(vert_cnt - 1));
        it.b = IDX_W'($urandom_range(vert_cnt - 1));
        it.c = IDX_W'($urandom_range(vert_cnt - 1));
      end
    end else if (pick < 50) begin
      it.op = OP_INVALID;
    end else if (tri_cnt > 0 && $urandom_range(9) < 7) begin
      // aim at a stored triangle: its centroid, a corner, or an edge midpoint
      t = $urandom_range(tri_cnt - 1);
      mode = $urandom_range(2);
      if (mode == 0) begin
        sx = longint'(mesh_x[tri_a[t]]) + mesh_x[tri_b[t]] + mesh_x[tri_c[t]];
        sy = longint'(mesh_y[tri_a[t]]) + mesh_y[tri_b[t]] + mesh_y[tri_c[t]];
        it.x = CRD_W'(sx / 3);
        it.y = CRD_W'(sy / 3);
      end else if (mode == 1) begin
        it.x = mesh_x[tri_b[t]];
        it.y = mesh_y[tri_b[t]];
      end else begin
        sx = longint'(mesh_x[tri_a[t]]) + mesh_x[tri_c[t]];
        sy = longint'(mesh_y[tri_a[t]]) + mesh_y[tri_c[t]];
        it.x = CRD_W'(sx / 2);
        it.y = CRD_W'(sy / 2);
      end
    end else begin
      it.x = near_coord();
      it.y = near_coord();
    end
    return it;
  endfunction

  function automatic row_t mk_row(op_e op, int x, int y, int z, int a, int b, int c,
                                  bit typed_exp = 1'b0,
                                  logic [STATUS_W-1:0] st = STAT_OK, int sl = 0);
    row_t r;
    r.item = '{op: op, x: x, y: y, z: z, a: IDX_W'(a), b: IDX_W'(b), c: IDX_W'(c)};
    r.typed_exp = typed_exp;
    r.exp = '{status: st, slot: IDX_W'(sl), height: '0};
    return r;
  endfunction

  // output checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 32'(status_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report("status", 32'(status_o), 32'(want.status));
        if (slot_o !== want.slot) report("slot", 32'(slot_o), 32'(want.slot));
        if (height_o !== want.height) report("height", height_o, want.height);
      end
    end
  end

  always @(negedge clk) begin
    out_stall_i <= recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
  end

  // watchdog on stretches with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    item_t it;
    // empty mesh, bad commands, extremes, degenerate and winding cases
    add_row(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 1, STAT_NOTFOUND));
    add_row(mk_row(OP_TRIANGLE, 0, 0, 0, 0, 1, 2, 1, STAT_BAD_IDX));
    add_row(mk_row(OP_INVALID, -1, -1, -1, 1023, 1023, 1023, 1,
                   STAT_BAD_IDX));
    add_row(mk_row(OP_VERTEX, 0, 0, 32'h0001_0000, 0, 0, 0, 1, STAT_OK, 0));
    add_row(mk_row(OP_VERTEX, 32'h0004_0000, 0, 32'h0002_0000, 0, 0, 0,
                   1, STAT_OK, 1));
    add_row(mk_row(OP_VERTEX, 0, 32'h0004_0000, -32'sh0003_0000, 0, 0, 0,
                   1, STAT_OK, 2));
    add_row(mk_row(OP_VERTEX, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                   0, 0, 0, 1, STAT_OK, 3));
    add_row(mk_row(OP_VERTEX, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   0, 0, 0, 1, STAT_OK, 4));
    add_row(mk_row(OP_VERTEX, 32'h0008_0000, 0, 0, 0, 0, 0, 1, STAT_OK, 5));
    // repeated corner and collinear corners
    add_row(mk_row(OP_TRIANGLE, 0, 0, 0, 0, 0, 1, 1, STAT_DEGEN));
    add_row(mk_row(OP_TRIANGLE, 0, 0, 0, 0, 1, 5, 1, STAT_DEGEN));
    add_row(mk_row(OP_TRIANGLE, 0, 0, 0, 0, 1, 1023, 1, STAT_BAD_IDX));
    add_row(mk_row(OP_TRIANGLE, 0, 0, 0, 0, 1, 2, 1, STAT_OK, 0));
    // opposite winding
    add_row(mk_row(OP_TRIANGLE, 0, 0, 0, 2, 1, 0, 1, STAT_OK, 1));
    add_row(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_QUERY, 32'h0002_0000, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_QUERY, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0));
    add_row(mk_row(OP_QUERY, -1, -1, 0, 0, 0, 0));
    add_row(mk_row(OP_VERTEX, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   0, 0, 0, 1, STAT_OK, 6));
    add_row(mk_row(OP_TRIANGLE, 0, 0, 0, 3, 4, 6));
    add_row(mk_row(OP_TRIANGLE, 0, 0, 0, 3, 4, 0));
    add_row(mk_row(OP_QUERY, 32'h7fff_0000, 32'h7fff_0000, 0, 0, 0, 0));
    add_row(mk_row(OP_QUERY, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0));
    add_row(mk_row(OP_QUERY, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed_exp, directed_rows[i].exp);
    end
    // sender holds off until the mesh has answered everything
    drain();

    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      if (n == 0) begin
        send_idle_pct = 37;
        recv_stall_pct = 72;
      end else if (n == NUM_RANDOM / 3) begin
        send_idle_pct = 72;
        recv_stall_pct = 37;
      end else if (n == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      send_item(random_item(), 1'b0, '0);
    end
    drain();

    // queries over everything stored so far
    it = '{op: OP_QUERY, x: 32'h0001_0000, y: 32'h0001_0000, z: '0, a: '0, b: '0, c: '0};
    send_item(it, 1'b0, '0);
    it = '{op: OP_QUERY, x: 32'h8000_0000, y: 32'h8000_0000, z: '0, a: '0, b: '0, c: '0};
    send_item(it, 1'b0, '0);
    drain();

    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tmhq_pkg.sv
sv/tmhq_front.sv
sv/tmhq_fifo.sv
sv/tmhq_div.sv
sv/tmhq_back.sv
sv/triangle_mesh_height_query_unit.sv
sim/tb_top.sv
